### src/fbcm_pkg.sv
// Shared types and constants for the FAT bad cluster marker.
`default_nettype none
package fbcm_pkg;

  localparam int unsigned TABLE_WORDS = 4096;
  localparam int unsigned TW_AW       = $clog2(TABLE_WORDS);
  // Full word address: wide enough for any entry address plus one.
  localparam int unsigned FA_W        = 17;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QP_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QC_W        = $clog2(QDEPTH + 1);

  localparam logic [15:0] ENTRY_RESERVED = 16'hFFFF;
  localparam logic [15:0] BAD_LO         = 16'hFFF0;
  localparam logic [15:0] BAD_HI         = 16'hFFFE;
  localparam logic [15:0] MARKER_RESET   = 16'hFFFE;
  localparam logic [7:0]  FOLD_NIBBLES   = 8'hFF;
  localparam logic [3:0]  FOLD_TOP       = 4'hF;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_READ   = 3'd1,
    OP_GET    = 3'd2,
    OP_MARK   = 3'd3,
    OP_UNMARK = 3'd4,
    OP_NOP    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_INUSE   = 3'd2,
    ST_ALREADY = 3'd3,
    ST_NOTBAD  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_WIDE   = 2'd0,
    CFG_MARKER = 2'd1,
    CFG_FORCE  = 2'd2,
    CFG_COUNT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_WR2,
    BK_HOLD
  } back_state_e;

  typedef struct packed {
    logic        wide;
    logic [15:0] bad_marker;
    logic        force_en;
    logic [15:0] entry_count;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [1:0]       pos;
    logic             low_entry;
    logic             range_bad;
    logic [TW_AW-1:0] idx0;
    logic [TW_AW-1:0] idx1;
    logic             ok0;
    logic             ok1;
    logic [15:0]      data;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] entry_value;
    logic [15:0] word_out;
    logic        is_bad;
    logic        modified;
  } res_t;

endpackage
`default_nettype wire

### src/fbcm_front.sv
// Front end: takes input transactions and turns them into table commands.
`default_nettype none
module fbcm_front import fbcm_pkg::*; (
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [15:0] entry_index_i,
  input  wire logic [11:0] word_addr_i,
  input  wire logic [15:0] word_data_i,
  input  wire cfg_t        cfg_i,
  input  wire logic        q_full_i,
  output      logic        q_push_o,
  output      cmd_t        cmd_o
);

  logic [17:0]     trip;
  logic [15:0]     base;
  logic [FA_W-1:0] addr0;
  logic [FA_W-1:0] addr1;
  op_e             op;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    case (kind_i)
      OP_LOAD:   op = OP_LOAD;
      OP_READ:   op = OP_READ;
      OP_GET:    op = OP_GET;
      OP_MARK:   op = OP_MARK;
      OP_UNMARK: op = OP_UNMARK;
      default:   op = OP_NOP;
    endcase
  end

  always_comb begin
    // Packed entry e starts in word (3e)/4.
    trip = {2'b00, entry_index_i} + {1'b0, entry_index_i, 1'b0};
    if (op == OP_LOAD || op == OP_READ) begin
      base = {4'h0, word_addr_i};
    end else if (cfg_i.wide) begin
      base = entry_index_i;
    end else begin
      base = trip[17:2];
    end
    addr0 = {1'b0, base};
    addr1 = addr0 + FA_W'(1);

    cmd_o.op        = op;
    cmd_o.pos       = entry_index_i[1:0];
    cmd_o.low_entry = (entry_index_i < 16'd2);
    cmd_o.range_bad = (entry_index_i < 16'd2) || (entry_index_i >= cfg_i.entry_count);
    cmd_o.idx0      = addr0[TW_AW-1:0];
    cmd_o.idx1      = addr1[TW_AW-1:0];
    cmd_o.ok0       = (addr0 < FA_W'(TABLE_WORDS));
    cmd_o.ok1       = (addr1 < FA_W'(TABLE_WORDS));
    cmd_o.data      = word_data_i;
  end

endmodule
`default_nettype wire

### src/fbcm_queue.sv
// Short command queue between the front end and the table engine.
`default_nettype none
module fbcm_queue import fbcm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      logic empty_o,
  output      cmd_t head_o
);

  cmd_t            slot_q [QDEPTH];
  logic [QP_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QC_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QC_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

### src/fbcm_back.sv
// Table engine: word memory, entry unpack and repack, result register.
`default_nettype none
module fbcm_back import fbcm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        q_empty_i,
  input  wire cmd_t        q_head_i,
  output      logic        q_pop_o,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  status_o,
  output      logic [15:0] entry_value_o,
  output      logic [15:0] word_out_o,
  output      logic        is_bad_o,
  output      logic        modified_o
);

  logic [15:0]      mem_q [TABLE_WORDS];
  logic [15:0]      rd0_q, rd1_q;
  cmd_t             cmd_q;
  back_state_e      state_q, state_d;
  logic             changed_q, changed_d;
  res_t             res_q, out_q;
  logic             out_valid_q;
  logic [15:0]      wr1_q;

  logic             mem_we;
  logic [TW_AW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             load_out;
  logic             sel_eval;
  logic             out_free;

  logic [15:0]      w0, w1;
  logic [11:0]      raw;
  logic [11:0]      v12;
  logic [15:0]      folded;
  logic [15:0]      ent;
  logic             ent_bad;
  logic             apply;
  logic             wr0;
  logic             second;
  logic [15:0]      nv;
  logic [15:0]      new0, new1;
  res_t             res;

  assign out_free = !out_valid_q || !out_stall_i;

  // Entry decode and update for the command whose words were just read.
  always_comb begin
    w0 = cmd_q.ok0 ? rd0_q : '0;
    w1 = cmd_q.ok1 ? rd1_q : '0;
    case (cmd_q.pos)
      2'd0:    raw = w0[11:0];
      2'd1:    raw = {w1[7:0], w0[15:12]};
      2'd2:    raw = {w1[3:0], w0[15:8]};
      default: raw = w0[15:4];
    endcase
    folded = (raw[11:4] == FOLD_NIBBLES) ? {FOLD_TOP, raw} : {4'h0, raw};
    if (cmd_q.low_entry) begin
      ent = ENTRY_RESERVED;
    end else if (cfg_i.wide) begin
      ent = w0;
    end else begin
      ent = folded;
    end
    ent_bad = (ent >= BAD_LO) && (ent <= BAD_HI);

    res    = '0;
    res.status = ST_OK;
    apply  = 1'b0;
    wr0    = 1'b0;
    nv     = '0;
    new0   = w0;
    new1   = w1;
    second = 1'b0;

    case (cmd_q.op)
      OP_LOAD: begin
        wr0  = 1'b1;
        new0 = cmd_q.data;
      end
      OP_READ: begin
        res.word_out = w0;
      end
      OP_GET: begin
        res.entry_value = ent;
      end
      OP_MARK: begin
        if (cmd_q.range_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.entry_value = ent;
          if (ent != '0 && !cfg_i.force_en) begin
            res.status = ent_bad ? ST_ALREADY : ST_INUSE;
          end else begin
            apply = 1'b1;
            nv    = cfg_i.bad_marker;
          end
        end
      end
      OP_UNMARK: begin
        if (cmd_q.range_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.entry_value = ent;
          if (!ent_bad && !cfg_i.force_en) begin
            res.status = ST_NOTBAD;
          end else begin
            apply = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res.is_bad   = (res.entry_value >= BAD_LO) && (res.entry_value <= BAD_HI);
    res.modified = changed_q || apply;

    v12 = nv[11:0];
    if (apply) begin
      wr0 = 1'b1;
      if (cfg_i.wide) begin
        new0 = nv;
      end else begin
        case (cmd_q.pos)
          2'd0: new0 = {w0[15:12], v12};
          2'd1: begin
            new0   = {v12[3:0], w0[11:0]};
            new1   = {w1[15:8], v12[11:4]};
            second = 1'b1;
          end
          2'd2: begin
            new0   = {v12[7:0], w0[7:0]};
            new1   = {w1[15:4], v12[11:8]};
            second = 1'b1;
          end
          default: new0 = {v12, w0[3:0]};
        endcase
      end
    end
  end

  // Sequencer: read both words, write the first, write the second if the
  // entry straddles, then hand the result to the output register.
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cmd_q.idx0;
    mem_wdata = new0;
    load_out  = 1'b0;
    sel_eval  = 1'b0;
    changed_d = changed_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = BK_EVAL;
        end
      end
      BK_EVAL: begin
        mem_we    = wr0 && cmd_q.ok0;
        changed_d = changed_q || apply;
        if (second) begin
          state_d = BK_WR2;
        end else if (out_free) begin
          load_out = 1'b1;
          sel_eval = 1'b1;
          state_d  = BK_IDLE;
        end else begin
          state_d = BK_HOLD;
        end
      end
      BK_WR2: begin
        mem_we    = cmd_q.ok1;
        mem_waddr = cmd_q.idx1;
        mem_wdata = wr1_q;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end else begin
          state_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      changed_q <= changed_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_head_i;
    end
    if (state_q == BK_EVAL) begin
      res_q <= res;
      wr1_q <= new1;
    end
    if (load_out) begin
      out_q <= sel_eval ? res : res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (q_pop_o) begin
      rd0_q <= mem_q[q_head_i.idx0];
      rd1_q <= mem_q[q_head_i.idx1];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign entry_value_o = out_q.entry_value;
  assign word_out_o    = out_q.word_out;
  assign is_bad_o      = out_q.is_bad;
  assign modified_o    = out_q.modified;

  a_wr2_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_WR2) |-> ($past(state_q) == BK_EVAL))
    else $error("second word write not preceded by evaluation");

  a_changed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(changed_q))
    else $error("modified flag cleared without reset");

  a_changed_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(changed_q) |-> ($past(state_q) == BK_EVAL))
    else $error("modified flag set outside evaluation");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == BK_EVAL || state_q == BK_WR2))
    else $error("table written outside a write phase");

endmodule
`default_nettype wire

### src/fat_bad_cluster_marker.sv
// A result is registered after the queue, the registered table read and evaluation, plus
// a second write state when a 12-bit mark or unmark rewrites a straddling entry. The
// engine takes a new transaction only once the last result is registered (table read,
// then evaluate and write, then the single write port's second write of a straddle).
// Reset clears the configuration (bad marker 0xFFFE), the queue, the modified flag and
// the output valid; table words hold no reset value and must be loaded before use.
`default_nettype none
module fat_bad_cluster_marker import fbcm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [15:0] entry_index_i,
  input  wire logic [11:0] word_addr_i,
  input  wire logic [15:0] word_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  status_o,
  output      logic [15:0] entry_value_o,
  output      logic [15:0] word_out_o,
  output      logic        is_bad_o,
  output      logic        modified_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide        <= 1'b0;
      cfg_q.bad_marker  <= MARKER_RESET;
      cfg_q.force_en    <= 1'b0;
      cfg_q.entry_count <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDE:   cfg_q.wide        <= cfg_data_i[0];
        CFG_MARKER: cfg_q.bad_marker  <= cfg_data_i;
        CFG_FORCE:  cfg_q.force_en    <= cfg_data_i[0];
        CFG_COUNT:  cfg_q.entry_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fbcm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .word_addr_i   (word_addr_i),
    .word_data_i   (word_data_i),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .cmd_o         (push_cmd)
  );

  fbcm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  fbcm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_head_i      (head_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .word_out_o    (word_out_o),
    .is_bad_o      (is_bad_o),
    .modified_o    (modified_o)
  );

endmodule
`default_nettype wire

### tb/fat_bad_cluster_marker_test.sv
// Self-checking testbench for the FAT bad cluster marker engine.
`timescale 1ns / 1ps
module fat_bad_cluster_marker_test;
  import fbcm_pkg::*;

  localparam int PRELOAD_WORDS  = 192;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    status_e     status;
    logic [15:0] entry_value;
    logic [15:0] word_out;
    logic        is_bad;
    logic        modified;
  } fat_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  kind_i;
  logic [15:0] entry_index_i;
  logic [11:0] word_addr_i;
  logic [15:0] word_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [15:0] entry_value_o;
  logic [15:0] word_out_o;
  logic        is_bad_o;
  logic        modified_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Mirror of the table, the sticky flag and the configuration.
  logic [15:0] fat_words [TABLE_WORDS];
  bit          word_loaded [TABLE_WORDS];
  int          loaded_addrs [$];
  bit          table_changed = 1'b0;
  bit          cfg_wide = 1'b0;
  logic [15:0] cfg_marker = MARKER_RESET;
  bit          cfg_force = 1'b0;
  int          cfg_count = 0;

  fat_result_t awaited_results [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          stall_cnt = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_request = 1'b0;
  logic        hold_rx = 1'b0;

  fat_bad_cluster_marker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .word_addr_i   (word_addr_i),
    .word_data_i   (word_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .word_out_o    (word_out_o),
    .is_bad_o      (is_bad_o),
    .modified_o    (modified_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] fetch_word(int a);
    return (a < TABLE_WORDS) ? fat_words[a] : 16'h0000;
  endfunction

  function automatic void put_word(int a, logic [15:0] v);
    if (a < TABLE_WORDS) fat_words[a] = v;
  endfunction

  function automatic bit bad_band(logic [15:0] v);
    return (v >= BAD_LO) && (v <= BAD_HI);
  endfunction

  function automatic logic [15:0] entry_of(int e);
    int          w;
    logic [15:0] v;
    if (e < 2) return ENTRY_RESERVED;
    if (cfg_wide) return fetch_word(e);
    w = (e * 3) >> 2;
    case (e % 4)
      0: v = fetch_word(w);
      1: v = (fetch_word(w) >> 12) | (fetch_word(w + 1) << 4);
      2: v = (fetch_word(w) >> 8) | (fetch_word(w + 1) << 8);
      default: v = fetch_word(w) >> 4;
    endcase
    v[15:12] = 4'h0;
    // fold 12-bit reserved and bad codes up to their 16-bit form
    if (v[11:4] == FOLD_NIBBLES) v[15:12] = FOLD_TOP;
    return v;
  endfunction

  function automatic void store_entry(int e, logic [15:0] val);
    int          w;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [11:0] v12;
    if (e < 2) return;
    if (cfg_wide) begin
      put_word(e, val);
      return;
    end
    v12 = val[11:0];
    w   = (e * 3) >> 2;
    lo  = fetch_word(w);
    hi  = fetch_word(w + 1);
    case (e % 4)
      0: put_word(w, {lo[15:12], v12});
      1: begin
        put_word(w, {v12[3:0], lo[11:0]});
        put_word(w + 1, {hi[15:8], v12[11:4]});
      end
      2: begin
        put_word(w, {v12[7:0], lo[7:0]});
        put_word(w + 1, {hi[15:4], v12[11:8]});
      end
      default: put_word(w, {v12, lo[3:0]});
    endcase
  endfunction

  function automatic fat_result_t apply_table_op(logic [2:0] kind, int e, int addr,
                                                 logic [15:0] data);
    fat_result_t r;
    logic [15:0] cur;
    bit          in_band;
    r.status      = ST_OK;
    r.entry_value = 16'h0000;
    r.word_out    = 16'h0000;
    case (kind)
      OP_LOAD: begin
        put_word(addr, data);
        if (!word_loaded[addr]) begin
          word_loaded[addr] = 1'b1;
          loaded_addrs.push_back(addr);
        end
      end
      OP_READ: r.word_out = fetch_word(addr);
      OP_GET:  r.entry_value = entry_of(e);
      OP_MARK, OP_UNMARK: begin
        if (e < 2 || e >= cfg_count) begin
          r.status = ST_RANGE;
        end else begin
          cur           = entry_of(e);
          r.entry_value = cur;
          in_band       = bad_band(cur);
          if (kind == OP_MARK) begin
            if (cur != 16'h0000 && !cfg_force) begin
              r.status = in_band ? ST_ALREADY : ST_INUSE;
            end else begin
              store_entry(e, cfg_marker);
              table_changed = 1'b1;
            end
          end else if (!in_band && !cfg_force) begin
            r.status = ST_NOTBAD;
          end else begin
            store_entry(e, 16'h0000);
            table_changed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.is_bad   = bad_band(r.entry_value);
    r.modified = table_changed;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // Never touch a table word inside the table that has not been loaded yet.
  function automatic bit word_ok(int a);
    return (a >= TABLE_WORDS) || word_loaded[a];
  endfunction

  function automatic bit entry_reachable(logic [2:0] kind, int e);
    int w;
    if (e < 2) return 1'b1;
    if ((kind == OP_MARK || kind == OP_UNMARK) && e >= cfg_count) return 1'b1;
    if (cfg_wide) return word_ok(e);
    w = (e * 3) >> 2;
    return word_ok(w) && word_ok(w + 1);
  endfunction

  function automatic int pick_entry(logic [2:0] kind);
    int pick;
    int e;
    int a;
    for (int tries = 0; tries < 16; tries++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        a = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
        e = cfg_wide ? a : (a * 4) / 3 + $urandom_range(0, 1);
      end else if (pick < 60) begin
        e = $urandom_range(0, 300);
      end else if (pick < 75) begin
        e = cfg_count + $urandom_range(0, 3) - 2;
        if (e < 0) e = 0;
        if (e > 65535) e = 65535;
      end else if (pick < 90) begin
        e = $urandom_range(0, 65535);
      end else begin
        e = $urandom_range(0, 1) ? $urandom_range(0, 1) : 65535;
      end
      if (entry_reachable(kind, e)) return e;
    end
    return $urandom_range(0, 1);
  endfunction

  function automatic logic [15:0] pattern_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return 16'h0000;
    if (pick < 45) return 16'(BAD_LO + $urandom_range(0, 15));
    if (pick < 55) return {4'($urandom_range(0, 15)), FOLD_NIBBLES, 4'($urandom_range(0, 15))};
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(int kind, int e, int addr, int data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind[2:0];
    entry_index_i <= e[15:0];
    word_addr_i   <= addr[11:0];
    word_data_i   <= data[15:0];
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(apply_table_op(kind[2:0], e, addr, data[15:0]));
    items_sent++;
  endtask

  // Drop valid and wait until every transaction in flight has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(bit wide, logic [15:0] marker, bit force_on,
                                logic [15:0] count);
    cfg_idx_e    order [4];
    logic [15:0] vals [4];
    order = '{CFG_WIDE, CFG_MARKER, CFG_FORCE, CFG_COUNT};
    vals  = '{{15'h0, wide}, marker, {15'h0, force_on}, count};
    settle();
    foreach (order[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (order[i])
        CFG_WIDE:   cfg_wide = vals[i][0];
        CFG_MARKER: cfg_marker = vals[i];
        CFG_FORCE:  cfg_force = vals[i][0];
        CFG_COUNT:  cfg_count = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_traffic_item();
    int pick;
    int e;
    int a;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_item(OP_LOAD, $urandom_range(0, 65535), $urandom_range(0, 4095), pattern_word());
    end else if (pick < 30) begin
      a = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
      send_item(OP_READ, $urandom_range(0, 65535), a, $urandom_range(0, 65535));
    end else if (pick < 45) begin
      send_item(OP_GET, pick_entry(OP_GET), $urandom_range(0, 4095), $urandom_range(0, 65535));
    end else if (pick < 62) begin
      send_item(OP_MARK, pick_entry(OP_MARK), $urandom_range(0, 4095),
                $urandom_range(0, 65535));
    end else if (pick < 75) begin
      send_item(OP_UNMARK, pick_entry(OP_UNMARK), $urandom_range(0, 4095),
                $urandom_range(0, 65535));
    end else if (pick < 95) begin
      // mark-and-recover on one entry, checking it between steps
      e = pick_entry(OP_GET);
      send_item(OP_GET, e, $urandom_range(0, 4095), $urandom_range(0, 65535));
      send_item(OP_MARK, e, $urandom_range(0, 4095), $urandom_range(0, 65535));
      send_item(OP_GET, e, $urandom_range(0, 4095), $urandom_range(0, 65535));
      send_item(OP_UNMARK, e, $urandom_range(0, 4095), $urandom_range(0, 65535));
      send_item(OP_GET, e, $urandom_range(0, 4095), $urandom_range(0, 65535));
    end else begin
      send_item(OP_NOP + $urandom_range(0, 2), $urandom_range(0, 65535),
                $urandom_range(0, 4095), $urandom_range(0, 65535));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic preload_table();
    for (int a = 0; a < PRELOAD_WORDS; a++)
      send_item(OP_LOAD, $urandom_range(0, 65535), a, pattern_word());
  endtask

  task automatic test_special_cases();
    apply_settings(1'b0, 16'hFFF7, 1'b0, 16'd200);
    send_item(OP_LOAD, 16'h0000, 0, 16'h0000);
    send_item(OP_LOAD, 16'hFFFF, 4095, 16'hFFFF);
    send_item(OP_READ, 16'h0000, 4095, 16'h0000);
    send_item(OP_READ, 16'hFFFF, 0, 16'hFFFF);
    send_item(OP_GET, 0, 0, 16'h0000);
    send_item(OP_GET, 1, 0, 16'h0000);
    // entry that falls beyond the table
    send_item(OP_GET, 16'hFFFF, 0, 16'h0000);
    send_item(OP_MARK, 1, 0, 16'h0000);
    send_item(OP_UNMARK, 200, 0, 16'h0000);
    send_item(OP_MARK, 16'hFFFF, 0, 16'h0000);
    send_item(OP_LOAD, 0, 3, 16'h0000);
    send_item(OP_LOAD, 0, 4, 16'h0000);
    // entry 5 straddles words 3 and 4
    send_item(OP_MARK, 5, 0, 16'h0000);
    send_item(OP_GET, 5, 0, 16'h0000);
    send_item(OP_MARK, 5, 0, 16'h0000);
    send_item(OP_UNMARK, 5, 0, 16'h0000);
    send_item(OP_UNMARK, 5, 0, 16'h0000);
    send_item(OP_LOAD, 0, 3, 16'h0FF0);
    send_item(OP_MARK, 4, 0, 16'h0000);
    send_item(OP_LOAD, 0, 4, 16'h0123);
    send_item(OP_MARK, 5, 0, 16'h0000);
    send_item(OP_NOP, 16'hFFFF, 4095, 16'hFFFF);
    send_item(OP_NOP + 1, 0, 0, 16'h0000);
    send_item(OP_NOP + 2, 16'hFFFF, 4095, 16'hFFFF);
    apply_settings(1'b0, 16'hFFF7, 1'b1, 16'd200);
    send_item(OP_MARK, 5, 0, 16'h0000);
    send_item(OP_UNMARK, 6, 0, 16'h0000);
    send_item(OP_MARK, 6, 0, 16'h0000);
  endtask

  task automatic test_random_traffic(bit wide, logic [15:0] marker, bit force_on,
                                     logic [15:0] count, int n);
    int stop;
    apply_settings(wide, marker, force_on, count);
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      random_traffic_item();
    end
    no_idle = 1'b0;
  endtask

  // Hold the result side off for a long stretch so the engine fills and stalls intake.
  task automatic test_backpressure();
    apply_settings(1'b0, MARKER_RESET, 1'b0, 16'hFFFF);
    no_idle      = 1'b1;
    hold_request = 1'b1;
    repeat (30) random_traffic_item();
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    fat_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", {13'h0, status_o}, {13'h0, want.status});
        check_field("entry_value", entry_value_o, want.entry_value);
        check_field("word_out", word_out_o, want.word_out);
        check_field("is_bad", {15'h0, is_bad_o}, {15'h0, want.is_bad});
        check_field("modified", {15'h0, modified_o}, {15'h0, want.modified});
      end
      stall_cnt = no_idle ? 0 : $urandom_range(0, 12);
    end else if (stall_cnt > 0) begin
      stall_cnt--;
    end
    out_stall_i <= hold_rx || (stall_cnt > 0);
  end

  initial begin
    forever begin
      wait (hold_request);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_rx      <= 1'b0;
      hold_request = 1'b0;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = OP_LOAD;
    entry_index_i = 16'h0000;
    word_addr_i   = 12'h000;
    word_data_i   = 16'h0000;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WIDE;
    cfg_data_i    = 16'h0000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    preload_table();
    test_special_cases();
    test_random_traffic(1'b0, MARKER_RESET, 1'b0, 16'hFFFF, 100);
    test_random_traffic(1'b1, BAD_LO, 1'b0, 16'd150, 100);
    test_random_traffic(1'b0, 16'h0FF5, 1'b1, 16'd180, 100);
    test_random_traffic(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 100);
    test_random_traffic(1'b0, 16'h0000, 1'b0, 16'd0, 60);
    test_random_traffic(1'b1, 16'($urandom), 1'($urandom_range(0, 1)),
                        16'($urandom_range(2, 190)), 100);
    test_random_traffic(1'b0, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom), 80);
    test_backpressure();

    settle();
    repeat (6) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
